FILE: hw/rtl/cpio_newc_entry_parser_core_assert.svh
// Assertion macros shared by the checker.
`ifndef CPIO_NEWC_ENTRY_PARSER_CORE_ASSERT_SVH
`define CPIO_NEWC_ENTRY_PARSER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CPIO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CPIO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cpio_pkg.sv
package cpio_pkg;

  localparam int HdrLen      = 110;
  localparam int FilesizePos = 54;
  localparam int NamesizePos = 94;
  localparam int TrailerLen  = 10;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_TRAILER = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_END = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_ACCEPT,
    S_EMIT_NAME,
    S_EMIT_RECORD,
    S_EMIT_FINISH,
    S_DONE
  } ctrl_state_t;

  // Datapath verdict on the byte just consumed.
  typedef struct packed {
    logic    emit_name;   // entry name replay, then record
    logic    emit_finish; // finish after (or instead of) the entry
    status_t fin_status;
    logic    name_empty;  // no name bytes to replay
  } dp_status_t;

  typedef struct packed {
    logic consume;     // take the input beat
    logic name_step;   // advance the replay pointer
    logic name_start;  // reset the replay pointer
  } dp_cmd_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    return d;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0, 3'd2, 3'd4: c = 8'h30;
      3'd1, 3'd3: c = 8'h37;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = 8'h54;
      4'd1: c = 8'h52;
      4'd2: c = 8'h41;
      4'd3: c = 8'h49;
      4'd4: c = 8'h4c;
      4'd5: c = 8'h45;
      4'd6: c = 8'h52;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/cpio_newc_entry_parser_core.sv
// A byte that closes no entry is consumed and yields nothing.
// A byte that closes an entry yields its first beat on the next cycle, then one beat
// per cycle while out_stall is low: name bytes, record, finish.
// Throughput: one byte per cycle; input stalls while a result burst is replayed and
// reopens the cycle after its last beat, since one name store serves both sides.
// Reset (rst, synchronous): back to header parsing at offset 0, parse and config registers cleared.
module cpio_newc_entry_parser_core import cpio_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  name_byte,
  output logic [6:0]  entry_index,
  output logic [31:0] file_size,
  output logic [31:0] data_address,
  output logic [1:0]  status,
  output logic        last
);

  logic [31:0] base_address, archive_size;

  // Config registers; the user must write them only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      archive_size <= '0;
    end else if (cfg_we) begin
      if (cfg_index) archive_size <= cfg_data;
      else base_address <= cfg_data;
    end
  end

  dp_cmd_t    cmd;
  dp_status_t verdict;
  dp_status_t st;
  logic       name_at_end;
  kind_t      out_kind;
  logic [7:0] raw_name;
  logic [6:0] raw_index;
  logic [31:0] raw_size, raw_address;

  // Controller: accept a byte, then drain the burst it caused.
  cpio_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_kind, .out_last(last), .cmd, .verdict, .st, .name_at_end
  );

  // Datapath: header decode, name capture, offsets and entry count.
  cpio_dp #(.MAX_ENTRIES(MAX_ENTRIES), .NAME_SLOTS(NAME_SLOTS)) u_dp (
    .clk, .rst, .base_address, .archive_size, .in_byte, .cmd, .verdict, .st,
    .name_at_end, .name_byte(raw_name), .entry_index(raw_index), .file_size(raw_size),
    .data_address(raw_address)
  );

  // The finish beat reports the count, which is the record index plus one
  // after a record, or equal to it otherwise.
  logic [6:0] count;
  assign count = raw_index + 7'(st.emit_name);

  cpio_out u_out (
    .out_kind, .fin_status(st.fin_status), .rec_index(raw_index), .count,
    .raw_name, .raw_size, .raw_address, .kind, .name_byte, .entry_index,
    .file_size, .data_address, .status
  );

endmodule

FILE: hw/rtl/cpio_ctrl.sv
module cpio_ctrl import cpio_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output kind_t      out_kind,
  output logic       out_last,
  output dp_cmd_t    cmd,
  input  dp_status_t verdict,
  input  dp_status_t st,
  input  logic       name_at_end
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_ACCEPT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    out_valid = 1'b0;
    out_kind = KIND_NAME;
    out_last = 1'b0;
    cmd = '0;
    case (state)
      S_ACCEPT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.consume = 1'b1;
          cmd.name_start = 1'b1;
          if (verdict.emit_name) begin
            state_next = verdict.name_empty ? S_EMIT_RECORD : S_EMIT_NAME;
          end else if (verdict.emit_finish) begin
            state_next = S_EMIT_FINISH;
          end
        end
      end
      S_EMIT_NAME: begin
        out_valid = 1'b1;
        out_kind = KIND_NAME;
        if (!out_stall) begin
          cmd.name_step = 1'b1;
          if (name_at_end) state_next = S_EMIT_RECORD;
        end
      end
      S_EMIT_RECORD: begin
        out_valid = 1'b1;
        out_kind = KIND_RECORD;
        out_last = !st.emit_finish;
        if (!out_stall) state_next = st.emit_finish ? S_EMIT_FINISH : S_ACCEPT;
      end
      S_EMIT_FINISH: begin
        out_valid = 1'b1;
        out_kind = KIND_FINISH;
        out_last = 1'b1;
        if (!out_stall) state_next = S_DONE;
      end
      S_DONE: in_stall = 1'b0;
      default: state_next = S_ACCEPT;
    endcase
  end

endmodule

FILE: hw/rtl/cpio_dp.sv
module cpio_dp import cpio_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] base_address,
  input  logic [31:0] archive_size,
  input  logic [7:0]  in_byte,
  input  dp_cmd_t     cmd,
  output dp_status_t  verdict,
  output dp_status_t  st,
  output logic        name_at_end,
  output logic [7:0]  name_byte,
  output logic [6:0]  entry_index,
  output logic [31:0] file_size,
  output logic [31:0] data_address
);

  localparam int NW = $clog2(NAME_SLOTS + 1);
  localparam int NA = $clog2(NAME_SLOTS);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [NW:0] EmitMax = (NW + 1)'(NAME_SLOTS - 1);

  typedef enum logic [1:0] {P_HEADER, P_NAME, P_DATA} phase_t;

  phase_t      phase;
  logic [31:0] byte_offset;
  logic [6:0]  header_pos;
  logic [31:0] name_field_size, data_field_size, region_remaining;
  logic        magic_ok, name_ended, trailer_match;
  logic [NW-1:0] name_length;
  logic [7:0]  name_store [NAME_SLOTS];
  logic [CW-1:0] entry_count;
  logic [NW-1:0] rd_ptr, rd_next, emit_len;
  logic [7:0]  rd_data;
  logic [7:0]  first_char;
  logic [31:0] rec_address;

  // combinational next-state of one consumed byte
  phase_t      ph_n;
  logic [31:0] off_n, nfs_n, dfs_n, rr_n;
  logic [6:0]  hp_n;
  logic        mok_n, ne_n, tm_n;
  logic [NW-1:0] nl_n;
  logic        wr_en;
  logic [NW-1:0] wr_addr;
  logic [CW-1:0] ec_n;
  dp_status_t  st_n;
  logic [32:0] pad33;
  logic [32:0] hdr_end;

  assign hdr_end = {1'b0, off_n} + 33'(HdrLen);
  assign verdict = st_n;

  always_comb begin
    ph_n = phase; off_n = byte_offset; hp_n = header_pos;
    nfs_n = name_field_size; dfs_n = data_field_size; rr_n = region_remaining;
    mok_n = magic_ok; ne_n = name_ended; tm_n = trailer_match;
    nl_n = name_length; ec_n = entry_count;
    wr_en = 1'b0; wr_addr = name_length;
    st_n = '0; pad33 = '0;
    if (phase == P_HEADER && header_pos == 7'd0 &&
        ({1'b0, byte_offset} + 33'(HdrLen)) > {1'b0, archive_size}) begin
      st_n.emit_finish = 1'b1; st_n.fin_status = ST_END;
    end else begin
      off_n = byte_offset + 32'd1;
      case (phase)
        P_HEADER: begin
          if (header_pos == 7'd0) mok_n = 1'b1;
          if (header_pos < 7'd6 && in_byte != magic_char(header_pos[2:0])) mok_n = 1'b0;
          if (header_pos >= 7'(FilesizePos) && header_pos < 7'(FilesizePos + 8))
            dfs_n = {data_field_size[27:0], hex_digit(in_byte)};
          if (header_pos >= 7'(NamesizePos) && header_pos < 7'(NamesizePos + 8))
            nfs_n = {name_field_size[27:0], hex_digit(in_byte)};
          hp_n = header_pos + 7'd1;
          if (hp_n == 7'(HdrLen)) begin
            if (!mok_n) begin
              st_n.emit_finish = 1'b1; st_n.fin_status = ST_BAD_MAGIC;
            end else begin
              pad33 = ({1'b0, nfs_n} + 33'(HdrLen + 3)) & ~33'd3;
              pad33 = pad33 - 33'(HdrLen);
              rr_n = pad33[32] ? 32'hFFFF_FFFF : pad33[31:0];
              ph_n = P_NAME; hp_n = 7'd0; nl_n = '0; ne_n = 1'b0; tm_n = 1'b1;
            end
          end
        end
        P_NAME: begin
          if (!name_ended && name_field_size != 32'd0) begin
            nfs_n = name_field_size - 32'd1;
            if (in_byte == 8'd0) ne_n = 1'b1;
            else begin
              if (header_pos >= 7'(TrailerLen) || in_byte != trailer_char(header_pos[3:0]))
                tm_n = 1'b0;
              if (name_length < NW'(NAME_SLOTS)) begin
                wr_en = 1'b1; nl_n = name_length + 1'b1;
              end
              if (header_pos < 7'd127) hp_n = header_pos + 7'd1;
              if (header_pos == 7'd1 && nl_n == NW'(2) && first_char == 8'h2e &&
                  in_byte == 8'h2f) nl_n = '0;
            end
          end
          rr_n = region_remaining - 32'd1;
          if (rr_n == 32'd0) begin
            if (tm_n && hp_n == 7'(TrailerLen)) begin
              st_n.emit_finish = 1'b1; st_n.fin_status = ST_TRAILER;
            end else begin
              if (!(hp_n == 7'd0 || (hp_n == 7'd1 && (header_pos == 7'd1 ?
                  first_char : in_byte) == 8'h2e))) begin
                st_n.emit_name = 1'b1;
                st_n.name_empty = (nl_n == '0);
                ec_n = entry_count + 1'b1;
                if (ec_n == CW'(MAX_ENTRIES)) begin
                  st_n.emit_finish = 1'b1; st_n.fin_status = ST_FULL;
                end
              end
              pad33 = ({1'b0, dfs_n} + 33'd3) & ~33'd3;
              if (pad33 == 33'd0) begin
                ph_n = P_HEADER; hp_n = 7'd0;
              end else begin
                ph_n = P_DATA; rr_n = pad33[32] ? 32'hFFFF_FFFF : pad33[31:0];
              end
            end
          end
        end
        default: begin
          rr_n = region_remaining - 32'd1;
          if (rr_n == 32'd0) begin
            ph_n = P_HEADER; hp_n = 7'd0;
          end
        end
      endcase
      if (!st_n.emit_finish) begin
        if (ph_n == P_HEADER && hp_n == 7'd0) begin
          if (hdr_end > {1'b0, archive_size}) begin
            st_n.emit_finish = 1'b1; st_n.fin_status = ST_END;
          end
        end else if (ph_n != P_HEADER && off_n >= archive_size) begin
          st_n.emit_finish = 1'b1; st_n.fin_status = ST_END;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_HEADER; byte_offset <= '0; header_pos <= '0;
      name_field_size <= '0; data_field_size <= '0; region_remaining <= '0;
      magic_ok <= 1'b1; name_length <= '0; name_ended <= 1'b0;
      trailer_match <= 1'b1; entry_count <= '0; st <= '0;
    end else if (cmd.consume) begin
      phase <= ph_n; byte_offset <= off_n; header_pos <= hp_n;
      name_field_size <= nfs_n; data_field_size <= dfs_n; region_remaining <= rr_n;
      magic_ok <= mok_n; name_length <= nl_n; name_ended <= ne_n;
      trailer_match <= tm_n; entry_count <= ec_n; st <= st_n;
    end
  end

  // Payload: name store, record fields, replay length.
  always_ff @(posedge clk) begin
    if (cmd.consume) begin
      if (wr_en) begin
        name_store[wr_addr[NA-1:0]] <= in_byte;
        if (wr_addr == '0) first_char <= in_byte;
      end
      rec_address <= base_address + off_n;
      emit_len <= ((NW + 1)'(nl_n) > EmitMax) ? EmitMax[NW-1:0] : nl_n;
    end
  end

  // Registered replay read; forward a byte written at the address being read.
  assign rd_next = cmd.name_start ? '0 : (cmd.name_step ? rd_ptr + 1'b1 : rd_ptr);

  always_ff @(posedge clk) begin
    rd_ptr <= rd_next;
    if (cmd.consume && wr_en && wr_addr == rd_next) rd_data <= in_byte;
    else rd_data <= name_store[rd_next[NA-1:0]];
  end

  logic [CW-1:0] rec_index;
  assign rec_index = entry_count - CW'(st.emit_name);
  assign name_at_end = (rd_ptr + 1'b1) == emit_len;
  assign name_byte = rd_data;
  assign entry_index = 7'(rec_index);
  assign file_size = data_field_size;
  assign data_address = rec_address;

endmodule

FILE: hw/rtl/cpio_out.sv
module cpio_out import cpio_pkg::*; (
  input  kind_t       out_kind,
  input  status_t     fin_status,
  input  logic [6:0]  rec_index,
  input  logic [6:0]  count,
  input  logic [7:0]  raw_name,
  input  logic [31:0] raw_size,
  input  logic [31:0] raw_address,
  output logic [1:0]  kind,
  output logic [7:0]  name_byte,
  output logic [6:0]  entry_index,
  output logic [31:0] file_size,
  output logic [31:0] data_address,
  output logic [1:0]  status
);
  // Zero the fields that do not belong to the beat kind.
  always_comb begin
    kind = out_kind;
    name_byte = (out_kind == KIND_NAME) ? raw_name : 8'd0;
    file_size = (out_kind == KIND_RECORD) ? raw_size : 32'd0;
    data_address = (out_kind == KIND_RECORD) ? raw_address : 32'd0;
    status = (out_kind == KIND_FINISH) ? fin_status : ST_TRAILER;
    entry_index = (out_kind == KIND_FINISH) ? count : rec_index;
  end
endmodule

FILE: hw/rtl/cpio_checker.sv
`include "cpio_newc_entry_parser_core_assert.svh"
module cpio_checker import cpio_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [1:0] status,
  input logic       last
);
  // Finish beats always close their burst.
  `CPIO_ASSERT_IMPL(a_fin_last, clk, rst, out_valid && kind == KIND_FINISH, last, "finish not last")
  // A name beat never ends a burst.
  `CPIO_ASSERT_IMPL(a_name_not_last, clk, rst, out_valid && kind == KIND_NAME, !last, "name last")
  // Input is held while results are pending.
  `CPIO_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, in_stall, "input open in burst")
  // Only a finish beat carries a status.
  `CPIO_ASSERT_IMPL(a_status_zero, clk, rst, out_valid && kind != KIND_FINISH, status == ST_TRAILER, "status on non-finish beat")
  // Stalled beat holds its kind.
  `CPIO_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(kind), "stalled beat changed")
endmodule

bind cpio_newc_entry_parser_core cpio_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .kind, .status, .last
);

FILE: sim/cpio_newc_entry_parser_core_tb.sv
module cpio_newc_entry_parser_core_tb;
  import cpio_pkg::*;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;
  localparam int TABLE_DEPTH = 64;
  localparam int STORE_DEPTH = 32;
  localparam logic [47:0] MAGIC_TEXT = "070701";
  localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";

  typedef enum logic [1:0] {PH_HDR, PH_NAME, PH_DATA, PH_FIN} parse_phase_t;

  // One output beat as the parser should produce it.
  typedef struct {
    kind_t       kind;
    logic [7:0]  nb;
    logic [6:0]  idx;
    logic [31:0] fsize;
    logic [31:0] addr;
    status_t     st;
    logic        last;
  } entry_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  name_byte;
  logic [6:0]  entry_index;
  logic [31:0] file_size;
  logic [31:0] data_address;
  logic [1:0]  status;
  logic        last;

  always #5 clk = ~clk;

  cpio_newc_entry_parser_core i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_byte,
    .out_valid, .out_stall, .kind, .name_byte, .entry_index,
    .file_size, .data_address, .status, .last
  );

  // Beats the archive parser owes us, oldest first.
  entry_beat_t pending_beats[$];
  int errors = 0;

  // Receiver-side knobs: quiet turns off random stalls, a bump of hold_req
  // asks for one long hold-off.
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int stall_left = 0;

  // ---------------------------------------------------------------------
  // Archive parser shadow: configuration and parse state
  // ---------------------------------------------------------------------
  logic [31:0]  base_reg = '0;
  logic [31:0]  size_reg = '0;
  parse_phase_t pr_ph = PH_HDR;
  logic [31:0]  pr_off = '0;
  logic [6:0]   pr_pos = '0;
  logic [31:0]  pr_nsz = '0;
  logic [31:0]  pr_dsz = '0;
  logic [31:0]  pr_rem = '0;
  bit           pr_magic = 1'b1;
  logic [7:0]   pr_store [STORE_DEPTH];
  int           pr_len = 0;
  bit           pr_ended = 1'b0;
  bit           pr_trail = 1'b1;
  int           pr_count = 0;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Hex digit value; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic bit header_fits();
    return ({32'd0, pr_off} + 64'd110) <= {32'd0, size_reg};
  endfunction

  function automatic logic [7:0] trailer_char(input int i);
    return TRAILER_TEXT[79 - 8 * i -: 8];
  endfunction

  task automatic owe_beat(input kind_t k, input logic [7:0] nb, input logic [31:0] fs,
                          input logic [31:0] addr, input status_t st);
    entry_beat_t e;
    e.kind = k;
    e.nb = nb;
    e.idx = pr_count[6:0];
    e.fsize = fs;
    e.addr = addr;
    e.st = st;
    e.last = 1'b0;
    pending_beats.push_back(e);
  endtask

  task automatic stop_parse(input status_t st);
    owe_beat(KIND_FINISH, 8'd0, 32'd0, 32'd0, st);
    pr_ph = PH_FIN;
  endtask

  task automatic header_char(input logic [7:0] b);
    int p;
    p = pr_pos;
    if (p == 0) pr_magic = 1'b1;
    if (p < 6 && b != MAGIC_TEXT[47 - 8 * p -: 8]) pr_magic = 1'b0;
    if (p >= 54 && p < 62) pr_dsz = {pr_dsz[27:0], nibble_of(b)};
    if (p >= 94 && p < 102) pr_nsz = {pr_nsz[27:0], nibble_of(b)};
    pr_pos = 7'(p + 1);
    if (pr_pos < 110) return;
    if (!pr_magic) begin
      stop_parse(ST_BAD_MAGIC);
      return;
    end
    pr_rem = sat32(((64'd113 + pr_nsz) & ~64'd3) - 64'd110);
    pr_ph = PH_NAME;
    pr_pos = '0;
    pr_len = 0;
    pr_ended = 1'b0;
    pr_trail = 1'b1;
  endtask

  // Name region done: stop at a trailer; else replay a kept name, post its record, go on to data.
  task automatic close_name();
    int raw;
    int k;
    bit skip;
    logic [31:0] dreg;
    raw = pr_pos;
    if (pr_trail && raw == 10) begin
      stop_parse(ST_TRAILER);
      return;
    end
    skip = (raw == 0) || (raw == 1 && pr_store[0] == ".");
    if (!skip) begin
      k = (pr_len < STORE_DEPTH - 1) ? pr_len : STORE_DEPTH - 1;
      for (int i = 0; i < k; i++) owe_beat(KIND_NAME, pr_store[i], 32'd0, 32'd0, ST_TRAILER);
      owe_beat(KIND_RECORD, 8'd0, pr_dsz, base_reg + pr_off, ST_TRAILER);
      pr_count++;
      if (pr_count >= TABLE_DEPTH) begin
        stop_parse(ST_FULL);
        return;
      end
    end
    dreg = sat32(({32'd0, pr_dsz} + 64'd3) & ~64'd3);
    if (dreg == 0) begin
      pr_ph = PH_HDR;
      pr_pos = '0;
    end else begin
      pr_ph = PH_DATA;
      pr_rem = dreg;
    end
  endtask

  task automatic name_char(input logic [7:0] b);
    int raw;
    raw = pr_pos;
    if (!pr_ended && pr_nsz != 0) begin
      pr_nsz--;
      if (b == 8'd0) begin
        pr_ended = 1'b1;
      end else begin
        if (raw >= 10 || b != trailer_char(raw)) pr_trail = 1'b0;
        if (pr_len < STORE_DEPTH) begin
          pr_store[pr_len] = b;
          pr_len++;
        end
        if (raw < 127) pr_pos = 7'(raw + 1);
        // strip a leading "./"
        if (raw == 1 && pr_len == 2 && pr_store[0] == "." && pr_store[1] == "/") pr_len = 0;
      end
    end
    pr_rem--;
    if (pr_rem == 0) close_name();
  endtask

  // Advance the shadow parser by one accepted archive byte.
  task automatic parse_byte(input logic [7:0] b);
    int n0;
    n0 = pending_beats.size();
    if (pr_ph == PH_FIN) return;
    if (pr_ph == PH_HDR && pr_pos == 0 && !header_fits()) begin
      stop_parse(ST_END);
    end else begin
      pr_off++;
      case (pr_ph)
        PH_HDR: header_char(b);
        PH_NAME: name_char(b);
        default: begin
          pr_rem--;
          if (pr_rem == 0) begin
            pr_ph = PH_HDR;
            pr_pos = '0;
          end
        end
      endcase
      if (pr_ph == PH_HDR && pr_pos == 0) begin
        if (!header_fits()) stop_parse(ST_END);
      end else if (pr_ph != PH_FIN && pr_ph != PH_HDR && pr_off >= size_reg) begin
        stop_parse(ST_END);
      end
    end
    if (pending_beats.size() > n0) pending_beats[$].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random short stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      out_stall <= 1'b1;
      stall_left <= 80;
      hold_seen <= hold_req;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_error(input string what, input entry_beat_t e);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: exp kind=%0d nb=%h idx=%0d fs=%h addr=%h st=%0d last=%0d",
               $realtime, what, e.kind, e.nb, e.idx, e.fsize, e.addr, e.st, e.last);
      $display("    got kind=%0d nb=%h idx=%0d fs=%h addr=%h st=%0d last=%0d",
               kind, name_byte, entry_index, file_size, data_address, status, last);
    end
  endtask

  // Compare every accepted result beat with the oldest one owed.
  always @(posedge clk) begin : check_beats
    entry_beat_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_beats.size() == 0) begin
        want = '{KIND_NAME, 8'd0, 7'd0, 32'd0, 32'd0, ST_TRAILER, 1'b0};
        flag_error("unexpected beat", want);
      end else begin
        want = pending_beats.pop_front();
        if (kind !== want.kind || name_byte !== want.nb || entry_index !== want.idx ||
            file_size !== want.fsize || data_address !== want.addr ||
            status !== want.st || last !== want.last)
          flag_error("mismatch", want);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Offer one byte, wait for the handshake, then advance the shadow parser.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
  endtask

  // Write a register with the parser drained; drop valid first.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_BASE) base_reg = val;
    else size_reg = val;
    cfg_we <= 1'b0;
  endtask

  // Hex digit text; a zero digit is sometimes junk, which decodes to zero.
  function automatic logic [7:0] hex_text(input logic [3:0] n);
    if (n == 0 && $urandom_range(0, 7) == 0) return 8'(8'h67 + $urandom_range(0, 19));
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  function automatic void text_name(input string s, ref logic [7:0] nm[$]);
    nm = {};
    for (int i = 0; i < s.len(); i++) nm.push_back(s[i]);
  endfunction

  // Build and send one archive entry; stop early once the parser has finished.
  task automatic send_entry(input logic [7:0] nm[$], input logic [31:0] ns,
                            input logic [31:0] fs, input bit bad_magic);
    logic [63:0] nreg;
    logic [63:0] dreg;
    logic [7:0] b;
    int badpos;
    badpos = bad_magic ? $urandom_range(0, 5) : -1;
    for (int i = 0; i < 110; i++) begin
      if (pr_ph == PH_FIN) return;
      if (i < 6) begin
        b = MAGIC_TEXT[47 - 8 * i -: 8];
        if (i == badpos) b = b ^ (8'd1 << $urandom_range(0, 7));
      end else if (i >= 54 && i < 62) begin
        b = hex_text(4'(fs >> (28 - 4 * (i - 54))));
      end else if (i >= 94 && i < 102) begin
        b = hex_text(4'(ns >> (28 - 4 * (i - 94))));
      end else begin
        b = $urandom_range(0, 255);
      end
      send_byte(b);
    end
    nreg = sat32(((64'd113 + ns) & ~64'd3) - 64'd110);
    for (logic [63:0] i = 0; i < nreg; i++) begin
      if (pr_ph == PH_FIN) return;
      if (i < nm.size()) b = nm[i];
      else if (i == nm.size()) b = 8'd0;
      else b = $urandom_range(0, 255);
      send_byte(b);
    end
    dreg = sat32(({32'd0, fs} + 64'd3) & ~64'd3);
    for (logic [63:0] i = 0; i < dreg; i++) begin
      if (pr_ph == PH_FIN) return;
      send_byte($urandom_range(0, 255));
    end
  endtask

  task automatic send_random_entry();
    logic [7:0] nm[$];
    logic [31:0] ns;
    logic [31:0] fs;
    int sel;
    int len;
    nm = {};
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      nm.push_back(".");
    end else if (sel <= 3) begin
      if (sel != 1) begin
        nm.push_back(".");
        nm.push_back("/");
      end
      len = (sel == 1) ? 0 : $urandom_range(0, 10);
      repeat (len) nm.push_back($urandom_range(1, 255));
    end else begin
      len = $urandom_range(1, 40);
      repeat (len) nm.push_back($urandom_range(1, 255));
    end
    case ($urandom_range(0, 7))
      0: ns = nm.size();
      1: ns = $urandom_range(0, nm.size());
      2: ns = nm.size() + $urandom_range(1, 9);
      default: ns = nm.size() + 1;
    endcase
    fs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
    send_entry(nm, ns, fs, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // A "./" name is stripped; the record address wraps past the top.
  task automatic test_directed();
    logic [7:0] nm[$];
    write_reg(REG_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    text_name("./x", nm);
    send_entry(nm, 4, 0, 1'b0);
    write_reg(REG_BASE, $urandom);
  endtask

  // Hold the receiver off while a long name arrives: the replay
  // burst backs up and the parser must stall its input.
  task automatic test_backpressure();
    logic [7:0] nm[$];
    nm = {};
    repeat (31) nm.push_back($urandom_range(1, 255));
    fork
      send_entry(nm, 32, $urandom_range(0, 6), 1'b0);
      begin
        wait (pr_ph == PH_NAME);
        hold_req++;
      end
    join
  endtask

  // End the archive one way, chosen at random; no idling from here on.
  task automatic test_finish();
    logic [7:0] nm[$];
    quiet = 1'b1;
    case ($urandom_range(0, 3))
      0: begin
        text_name("TRAILER!!!", nm);
        send_entry(nm, 11, 0, 1'b0);
      end
      1: begin
        text_name("z", nm);
        send_entry(nm, 2, 0, 1'b1);
      end
      2: begin
        write_reg(REG_SIZE, $urandom_range(0, 1) ? 32'd0 : pr_off + $urandom_range(0, 109));
        send_byte($urandom_range(0, 255));
      end
      default: begin
        write_reg(REG_SIZE, pr_off + 110 + $urandom_range(0, 40));
        text_name("cutshort", nm);
        if ($urandom_range(0, 2) == 0) send_entry(nm, 32'hFFFF_FFF0, 30, 1'b0);
        else send_entry(nm, 9, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd30, 1'b0);
      end
    endcase
    while (pr_ph != PH_FIN) send_random_entry();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BASE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_finish();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
